@@ rtl/prtt_pkg.sv @@
// Package for the pending request tag table.
// Holds table sizing, command codes, sequencer states and the structs shared by
// the RTL files. No dependencies.
`default_nettype none

package prtt_pkg;

	localparam int PENDING_SLOTS = 128;
	localparam int TABLE_DEPTH   = PENDING_SLOTS + 1;
	localparam int SLOT_AW       = $clog2(TABLE_DEPTH);

	typedef logic [SLOT_AW-1:0] slot_addr_t;

	localparam slot_addr_t SLOT_LAST   = SLOT_AW'(PENDING_SLOTS);
	localparam logic [7:0] HANDLE_LAST = 8'(PENDING_SLOTS);

	typedef enum logic [2:0] {
		CMD_ALLOC       = 3'd0,
		CMD_VALIDATE    = 3'd1,
		CMD_QUERY       = 3'd2,
		CMD_SET_CHANNEL = 3'd3,
		CMD_REMOVE      = 3'd4
	} prtt_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SCAN,
		ST_CLAIM,
		ST_EXEC,
		ST_DONE
	} prtt_state_t;

	typedef struct packed {
		logic [2:0]  command;
		logic [7:0]  handle;
		logic [7:0]  request_type;
		logic [7:0]  response_type;
		logic        has_app_context;
		logic [63:0] app_context;
		logic [7:0]  channel;
	} prtt_item_t;

	typedef struct packed {
		logic [7:0]  request_type;
		logic [7:0]  response_type;
		logic        app_flag;
		logic [63:0] app_word;
		logic [7:0]  channel;
	} prtt_entry_t;

	typedef struct packed {
		logic [7:0]  handle_out;
		logic        ok;
		logic [7:0]  stored_request_type;
		logic [7:0]  stored_response_type;
		logic        stored_has_app_context;
		logic [63:0] stored_app_context;
		logic [7:0]  stored_channel;
	} prtt_res_t;

	typedef struct packed {
		logic        rd_en;
		slot_addr_t  rd_addr;
		logic        wr_en;
		logic        clr_en;
		slot_addr_t  wr_addr;
		prtt_entry_t wr_data;
		slot_addr_t  probe_addr;
	} prtt_ram_req_t;

	typedef struct packed {
		prtt_entry_t rd_data;
		logic        probe_live;
	} prtt_ram_rsp_t;

endpackage

`default_nettype wire

@@ rtl/prtt_ifs.sv @@
// Channel interfaces of the pending request tag table: command beats,
// result beats and the configuration write channel. No dependencies.
`default_nettype none

interface prtt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [7:0]  handle;
	logic [7:0]  request_type;
	logic [7:0]  response_type;
	logic        has_app_context;
	logic [63:0] app_context;
	logic [7:0]  channel;

	modport source (
		output valid, command, handle, request_type, response_type,
		output has_app_context, app_context, channel,
		input  ready
	);
	modport sink (
		input  valid, command, handle, request_type, response_type,
		input  has_app_context, app_context, channel,
		output ready
	);
endinterface

interface prtt_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  handle_out;
	logic        ok;
	logic [7:0]  stored_request_type;
	logic [7:0]  stored_response_type;
	logic        stored_has_app_context;
	logic [63:0] stored_app_context;
	logic [7:0]  stored_channel;

	modport source (
		output valid, handle_out, ok, stored_request_type, stored_response_type,
		output stored_has_app_context, stored_app_context, stored_channel,
		input  ready
	);
	modport sink (
		input  valid, handle_out, ok, stored_request_type, stored_response_type,
		input  stored_has_app_context, stored_app_context, stored_channel,
		output ready
	);
endinterface

interface prtt_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] fault_response_code;

	modport source (output valid, fault_response_code, input ready);
	modport sink (input valid, fault_response_code, output ready);
endinterface

`default_nettype wire

@@ rtl/prtt_slot_ram.sv @@
// Slot storage of the pending request tag table: one-read one-write memory
// with registered read, plus per-slot valid and live flags. Uses prtt_pkg.
`default_nettype none

module prtt_slot_ram
	import prtt_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire prtt_ram_req_t req,
	output prtt_ram_rsp_t      rsp
);

	prtt_entry_t            mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [TABLE_DEPTH-1:0] live_q;
	prtt_entry_t            rd_data_q;
	logic                   rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	// never-written or removed slots read back as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			live_q     <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.clr_en) begin
				valid_q[req.wr_addr] <= 1'b0;
				live_q[req.wr_addr]  <= 1'b0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
				live_q[req.wr_addr]  <= (req.wr_data.response_type != '0);
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rsp.rd_data    = rd_valid_q ? rd_data_q : '0;
	assign rsp.probe_live = live_q[req.probe_addr];

endmodule

`default_nettype wire

@@ rtl/prtt_ctrl.sv @@
// Command sequencer of the pending request tag table: decodes one command,
// steps the shared search cursor slot by slot and drives the slot memory.
// Uses prtt_pkg; works against prtt_slot_ram.
`default_nettype none

module prtt_ctrl
	import prtt_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          item_valid,
	output logic               item_ready,
	input  wire prtt_item_t    item,
	input  wire logic [7:0]    fault_code,
	output prtt_ram_req_t      ram_req,
	input  wire prtt_ram_rsp_t ram_rsp,
	output logic               res_valid,
	input  wire logic          res_take,
	output prtt_res_t          res
);

	prtt_state_t state_q, state_d;
	prtt_item_t  item_q;
	slot_addr_t  cursor_q;
	slot_addr_t  start_q;
	prtt_res_t   res_q;
	prtt_res_t   exec_res;

	slot_addr_t  step;
	logic        in_range;
	logic        live_rd;
	logic        resp_match;
	logic        chan_match;
	logic        wrapped;
	logic        found;
	prtt_entry_t entry;

	// shared cursor step: one slot per cycle, modulo the table depth
	assign step       = (cursor_q == SLOT_LAST) ? '0 : cursor_q + SLOT_AW'(1);
	assign wrapped    = (step == start_q);
	assign found      = !wrapped && (step != '0) && !ram_rsp.probe_live;
	assign in_range   = (item_q.handle != '0) && (item_q.handle <= HANDLE_LAST);
	assign entry      = ram_rsp.rd_data;
	assign live_rd    = (entry.response_type != '0);
	assign resp_match = (entry.response_type == item_q.response_type)
		|| (item_q.response_type == fault_code);
	assign chan_match = (entry.channel == item_q.channel);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (item_q.command == CMD_ALLOC) begin
					state_d = (item_q.response_type == '0) ? ST_DONE : ST_SCAN;
				end else begin
					state_d = ST_EXEC;
				end
			end
			ST_SCAN: begin
				if (wrapped) state_d = ST_DONE;
				else if (found) state_d = ST_CLAIM;
			end
			ST_CLAIM: state_d = ST_DONE;
			ST_EXEC:  state_d = ST_DONE;
			ST_DONE: begin
				if (res_take) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready         = (state_q == ST_IDLE);
		res_valid          = (state_q == ST_DONE);
		ram_req            = '0;
		ram_req.probe_addr = step;
		unique case (state_q)
			ST_LOOKUP: begin
				ram_req.rd_en   = (item_q.command != CMD_ALLOC) && in_range;
				ram_req.rd_addr = item_q.handle[SLOT_AW-1:0];
			end
			ST_SCAN: begin
				// fetch the claimed slot so its channel survives the claim
				ram_req.rd_en   = found;
				ram_req.rd_addr = step;
			end
			ST_CLAIM: begin
				ram_req.wr_en                 = 1'b1;
				ram_req.wr_addr               = cursor_q;
				ram_req.wr_data.request_type  = item_q.request_type;
				ram_req.wr_data.response_type = item_q.response_type;
				ram_req.wr_data.app_flag      = item_q.has_app_context;
				ram_req.wr_data.app_word      = item_q.app_context;
				ram_req.wr_data.channel       = entry.channel;
			end
			ST_EXEC: begin
				ram_req.wr_addr = item_q.handle[SLOT_AW-1:0];
				ram_req.wr_data = entry;
				ram_req.wr_data.channel = item_q.channel;
				ram_req.wr_en  = (item_q.command == CMD_SET_CHANNEL) && in_range;
				ram_req.clr_en = (item_q.command == CMD_REMOVE) && in_range;
			end
			ST_IDLE, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		exec_res = '0;
		case (item_q.command)
			CMD_VALIDATE: begin
				exec_res.ok = in_range && live_rd && resp_match && chan_match;
			end
			CMD_QUERY: begin
				if (in_range) begin
					exec_res.ok                     = live_rd;
					exec_res.stored_request_type    = entry.request_type;
					exec_res.stored_response_type   = entry.response_type;
					exec_res.stored_has_app_context = entry.app_flag;
					exec_res.stored_app_context     = entry.app_word;
					exec_res.stored_channel         = live_rd ? entry.channel : '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cursor_q <= '0;
			start_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_LOOKUP) start_q <= cursor_q;
			if (state_q == ST_SCAN) cursor_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) item_q <= item;
		unique case (state_q)
			ST_LOOKUP: res_q <= '0;
			ST_CLAIM:  res_q.handle_out <= 8'(cursor_q);
			ST_EXEC:   res_q <= exec_res;
			default: begin
			end
		endcase
	end

	assign res = res_q;

endmodule

`default_nettype wire

@@ rtl/pending_request_tag_table.sv @@
// Top level of the pending request tag table: channel ports, fault code
// register and result register. Uses prtt_pkg, prtt_ifs, prtt_ctrl and
// prtt_slot_ram.
`default_nettype none

// Pending request tag table. Holds PENDING_SLOTS request slots, handles 1 to
// PENDING_SLOTS, each with request type, expected response type, context flag,
// 64-bit context word and channel. A slot is live while its response type is
// nonzero. Every command beat yields exactly one result beat. Allocate steps a
// round-robin cursor forward one slot per cycle (slot 0 skipped, the start slot
// never tested) and claims the first free slot; handle_out is 0 if the response
// type is 0 or the table is full. Validate, query, set channel and remove
// address one slot. One command is worked on at a time: the command port is
// ready only when the sequencer is idle. Validate, query, set channel, remove
// and unused codes pass through the lookup and execute states before the
// result is ready; a refused allocate goes from lookup straight to done. An
// allocate that claims a slot passes through lookup, scan and claim; on a full
// table the cursor steps through all PENDING_SLOTS + 1 slots and the result is
// the slowest of any command, set by the cursor stepping through the per-slot
// live flags. The command port is ready again from the edge that moves the
// result to the output register. A finished result sits in the output
// register, and the next command is taken while it waits there.
// After reset all slots read as free and zero at once; no clearing pass. The
// fault response code (reset 1) may be written only while the block is idle.
module pending_request_tag_table
	import prtt_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	prtt_req_if.sink  req_ch,
	prtt_rsp_if.source rsp_ch,
	prtt_cfg_if.sink  cfg_ch
);

	logic [7:0]    fault_code_q;
	logic          out_valid_q;
	prtt_res_t     out_q;

	prtt_item_t    item;
	prtt_res_t     res;
	logic          res_valid;
	logic          res_take;
	prtt_ram_req_t ram_req;
	prtt_ram_rsp_t ram_rsp;

	// command beat into the sequencer
	assign item.command         = req_ch.command;
	assign item.handle          = req_ch.handle;
	assign item.request_type    = req_ch.request_type;
	assign item.response_type   = req_ch.response_type;
	assign item.has_app_context = req_ch.has_app_context;
	assign item.app_context     = req_ch.app_context;
	assign item.channel         = req_ch.channel;

	prtt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (req_ch.valid),
		.item_ready (req_ch.ready),
		.item       (item),
		.fault_code (fault_code_q),
		.ram_req    (ram_req),
		.ram_rsp    (ram_rsp),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res)
	);

	prtt_slot_ram u_slot_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ram_req),
		.rsp    (ram_rsp)
	);

	// config register: always ready, single register
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fault_code_q <= 8'd1;
		end else if (cfg_ch.valid) begin
			fault_code_q <= cfg_ch.fault_response_code;
		end
	end

	// output register: loads when empty or being drained this cycle
	assign res_take = res_valid && (!out_valid_q || rsp_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) out_q <= res;
	end

	assign rsp_ch.valid                  = out_valid_q;
	assign rsp_ch.handle_out             = out_q.handle_out;
	assign rsp_ch.ok                     = out_q.ok;
	assign rsp_ch.stored_request_type    = out_q.stored_request_type;
	assign rsp_ch.stored_response_type   = out_q.stored_response_type;
	assign rsp_ch.stored_has_app_context = out_q.stored_has_app_context;
	assign rsp_ch.stored_app_context     = out_q.stored_app_context;
	assign rsp_ch.stored_channel         = out_q.stored_channel;

`ifndef SYNTHESIS
	// one command at a time: port drops ready right after a beat
	a_single_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		req_ch.valid && req_ch.ready |=> !req_ch.ready)
		else $error("command accepted while sequencer busy");

	a_handle_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ch.valid |-> rsp_ch.handle_out <= HANDLE_LAST)
		else $error("allocated handle out of range");

	// an allocate result never carries a validate or query verdict
	a_alloc_no_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ch.valid && rsp_ch.handle_out != 8'd0 |-> !rsp_ch.ok)
		else $error("allocate result with ok set");

	a_chan_live: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ch.valid && !rsp_ch.ok |-> rsp_ch.stored_channel == 8'd0)
		else $error("channel reported for a slot that is not live");
`endif

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Testbench for pending_request_tag_table: directed and random command beats
// checked against a cycle-free model of the slot table kept in this file.
// Depends on rtl/prtt_pkg.sv, rtl/prtt_ifs.sv and the table RTL.
`timescale 1ns / 100ps

module tb;
	import prtt_pkg::*;

	localparam int          HALF_PERIOD    = 4;
	localparam int          STALL_LIMIT    = 3000; // cycles with no beat on any channel
	localparam int          HOLD_OFF_LEN   = 400;  // long result back-pressure stretch
	localparam int          IDLE_PCT       = 31;
	localparam logic [7:0]  RESP_FREE      = 8'h00; // response type of a free slot
	localparam logic [7:0]  FAULT_RESET    = 8'h01;
	localparam logic [2:0]  CMD_SPARE_LO   = CMD_REMOVE + 3'd1;
	localparam logic [2:0]  CMD_SPARE_HI   = 3'h7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	prtt_req_if req_ch();
	prtt_rsp_if rsp_ch();
	prtt_cfg_if cfg_ch();

	pending_request_tag_table dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req_ch (req_ch.sink),
		.rsp_ch (rsp_ch.source),
		.cfg_ch (cfg_ch.sink)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow copy of the slot table, cursor and fault code. Updated at the
	// edge where a command beat is accepted, so it always reflects every
	// command the block has taken so far.
	// ------------------------------------------------------------------
	prtt_entry_t slot_tbl [TABLE_DEPTH];
	logic [7:0]  tag_cursor;
	logic [7:0]  fault_code;

	prtt_res_t   result_q [$];   // predicted result beats, oldest first
	int unsigned mismatches = 0;

	// Knobs shared by the test tasks and the channel processes.
	int unsigned req_idle_pct = IDLE_PCT;
	int unsigned rsp_idle_pct = IDLE_PCT;
	int unsigned rsp_hold_cycles = 0;

	function automatic logic in_range(logic [7:0] h);
		return h != 8'd0 && h <= HANDLE_LAST;
	endfunction

	function automatic int unsigned live_count();
		int unsigned n;
		n = 0;
		for (int i = 1; i < TABLE_DEPTH; i++)
			if (slot_tbl[i].response_type != RESP_FREE)
				n++;
		return n;
	endfunction

	// Works out the result beat of one command and applies its side effects.
	function automatic prtt_res_t predict_result(prtt_item_t it);
		prtt_res_t   r;
		int unsigned cur;
		logic        found;
		logic        live;
		r = '0;
		case (it.command)
		CMD_ALLOC: begin
			// Zero response type is refused outright; cursor stays put.
			if (it.response_type != RESP_FREE) begin
				cur = tag_cursor;
				found = 1'b0;
				// Step at most once around; the start slot itself is never tested.
				repeat (TABLE_DEPTH - 1) begin
					if (!found) begin
						cur = (cur + 1) % TABLE_DEPTH;
						found = cur != 0 && slot_tbl[cur].response_type == RESP_FREE;
					end
				end
				// A full table wraps back to the start: cursor unchanged.
				if (found) begin
					tag_cursor = 8'(cur);
					slot_tbl[cur].request_type  = it.request_type;
					slot_tbl[cur].response_type = it.response_type;
					slot_tbl[cur].app_flag      = it.has_app_context;
					slot_tbl[cur].app_word      = it.app_context;
					r.handle_out = 8'(cur);
				end
			end
		end
		CMD_VALIDATE: begin
			if (in_range(it.handle) && slot_tbl[it.handle].response_type != RESP_FREE &&
			    (slot_tbl[it.handle].response_type == it.response_type ||
			     it.response_type == fault_code) &&
			    slot_tbl[it.handle].channel == it.channel)
				r.ok = 1'b1;
		end
		CMD_QUERY: begin
			if (in_range(it.handle)) begin
				live = slot_tbl[it.handle].response_type != RESP_FREE;
				r.ok                     = live;
				r.stored_request_type    = slot_tbl[it.handle].request_type;
				r.stored_response_type   = slot_tbl[it.handle].response_type;
				r.stored_has_app_context = slot_tbl[it.handle].app_flag;
				r.stored_app_context     = slot_tbl[it.handle].app_word;
				// Channel of a free slot reads back as 0 even if one was set.
				r.stored_channel         = live ? slot_tbl[it.handle].channel : 8'd0;
			end
		end
		CMD_SET_CHANNEL: begin
			// Written even on a free slot; it sticks until the slot is removed.
			if (in_range(it.handle))
				slot_tbl[it.handle].channel = it.channel;
		end
		CMD_REMOVE: begin
			if (in_range(it.handle))
				slot_tbl[it.handle] = '0;
		end
		default: ; // spare codes: no effect, all-zero result
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Command channel driver. Valid stays up after a beat until the next
	// call either offers a new command or idles, so it never toggles twice
	// in one step.
	// ------------------------------------------------------------------
	task automatic send_cmd(input prtt_item_t it);
		while ($urandom_range(99) < req_idle_pct) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
		@(negedge clk);
		req_ch.valid           <= 1'b1;
		req_ch.command         <= it.command;
		req_ch.handle          <= it.handle;
		req_ch.request_type    <= it.request_type;
		req_ch.response_type   <= it.response_type;
		req_ch.has_app_context <= it.has_app_context;
		req_ch.app_context     <= it.app_context;
		req_ch.channel         <= it.channel;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		result_q.push_back(predict_result(it));
	endtask

	// Drop valid, then hold until every predicted result beat has come back.
	task automatic wait_drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Fault code writes happen only with the table idle.
	task automatic write_fault_code(input logic [7:0] code);
		wait_drain();
		@(negedge clk);
		cfg_ch.valid               <= 1'b1;
		cfg_ch.fault_response_code <= code;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		fault_code = code;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic prtt_item_t mk_cmd(logic [2:0] command, logic [7:0] handle,
	                                      logic [7:0] req_type, logic [7:0] resp_type,
	                                      logic flag, logic [63:0] word,
	                                      logic [7:0] chan);
		prtt_item_t it;
		it.command         = command;
		it.handle          = handle;
		it.request_type    = req_type;
		it.response_type   = resp_type;
		it.has_app_context = flag;
		it.app_context     = word;
		it.channel         = chan;
		return it;
	endfunction

	// Mostly a live handle when one exists; otherwise anywhere, now and then
	// past the last slot.
	function automatic logic [7:0] pick_handle(int unsigned live_pct);
		logic [7:0] live_q [$];
		for (int i = 1; i < TABLE_DEPTH; i++)
			if (slot_tbl[i].response_type != RESP_FREE)
				live_q.push_back(8'(i));
		if (live_q.size() != 0 && $urandom_range(99) < live_pct)
			return live_q[$urandom_range(live_q.size() - 1)];
		if ($urandom_range(99) < 15)
			return 8'($urandom_range(255));
		return 8'($urandom_range(PENDING_SLOTS));
	endfunction

	function automatic logic [63:0] rand_word();
		case ($urandom_range(9))
		0:       return '0;
		1:       return '1;
		default: return {$urandom, $urandom};
		endcase
	endfunction

	// Random command with content shaped so that most validates and queries
	// hit live slots with matching fields. fill_pct biases allocate vs remove.
	function automatic prtt_item_t rand_cmd(int unsigned fill_pct);
		prtt_item_t  it;
		int unsigned sel;
		int unsigned alloc_w;
		int unsigned remove_w;
		logic [7:0]  h;
		it = mk_cmd(CMD_ALLOC, 8'($urandom), 8'($urandom), 8'($urandom),
		            1'($urandom), rand_word(), 8'($urandom));
		alloc_w  = (live_count() > PENDING_SLOTS * 3 / 4) ? fill_pct / 2 : fill_pct;
		remove_w = (live_count() > PENDING_SLOTS * 3 / 4) ? 30 : 12;
		sel = $urandom_range(99);
		if (sel < alloc_w) begin
			it.command = CMD_ALLOC;
			if ($urandom_range(99) < 6)
				it.response_type = RESP_FREE;
			else if ($urandom_range(99) < 10)
				it.response_type = fault_code;
			else
				it.response_type = 8'($urandom_range(255, 1));
		end else if (sel < alloc_w + 28) begin
			it.command = CMD_VALIDATE;
			h = pick_handle(85);
			it.handle = h;
			if (in_range(h)) begin
				case ($urandom_range(9))
				0, 1:    it.response_type = fault_code;
				2, 3:    it.response_type = 8'($urandom);
				default: it.response_type = slot_tbl[h].response_type;
				endcase
				if ($urandom_range(99) < 75)
					it.channel = slot_tbl[h].channel;
			end
		end else if (sel < alloc_w + 43) begin
			it.command = CMD_QUERY;
			it.handle  = pick_handle(70);
		end else if (sel < alloc_w + 55) begin
			it.command = CMD_SET_CHANNEL;
			it.handle  = pick_handle(70);
			if ($urandom_range(99) < 15)
				it.channel = 8'd0;
		end else if (sel < alloc_w + 55 + remove_w) begin
			it.command = CMD_REMOVE;
			it.handle  = pick_handle(85);
		end else begin
			it.command = 3'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
		end
		return it;
	endfunction

	// ------------------------------------------------------------------
	// Result channel: random ready, or a long hold-off when a test asks
	// for one. One assignment per falling edge.
	// ------------------------------------------------------------------
	always begin : rsp_ready_drive
		@(negedge clk);
		if (rsp_hold_cycles != 0) begin
			rsp_ch.ready <= 1'b0;
			repeat (rsp_hold_cycles - 1) @(negedge clk);
			rsp_hold_cycles = 0;
		end else begin
			rsp_ch.ready <= $urandom_range(99) >= rsp_idle_pct;
		end
	end

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Every result beat against the oldest prediction.
	prtt_res_t want_res;
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (result_q.size() == 0) begin
				$error("result beat with nothing predicted: handle_out %0h ok %0b",
				       rsp_ch.handle_out, rsp_ch.ok);
				mismatches++;
			end else begin
				want_res = result_q.pop_front();
				check_field("handle_out", 64'(want_res.handle_out),
				            64'(rsp_ch.handle_out));
				check_field("ok", 64'(want_res.ok), 64'(rsp_ch.ok));
				check_field("stored_request_type", 64'(want_res.stored_request_type),
				            64'(rsp_ch.stored_request_type));
				check_field("stored_response_type", 64'(want_res.stored_response_type),
				            64'(rsp_ch.stored_response_type));
				check_field("stored_has_app_context",
				            64'(want_res.stored_has_app_context),
				            64'(rsp_ch.stored_has_app_context));
				check_field("stored_app_context", want_res.stored_app_context,
				            rsp_ch.stored_app_context);
				check_field("stored_channel", 64'(want_res.stored_channel),
				            64'(rsp_ch.stored_channel));
			end
		end
	end

	// Watchdog: any beat on any channel counts as progress.
	int unsigned quiet_cycles = 0;
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
		    (cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$error("no beat accepted for %0d cycles, %0d results outstanding",
			       STALL_LIMIT, result_q.size());
			$display("tb: FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Every command once, field extremes, refused allocate, out-of-range
	// handles, channel on a free slot, spare command codes.
	task automatic test_directed_ops();
		send_cmd(mk_cmd(CMD_ALLOC, 8'hFF, 8'hFF, 8'hFF, 1'b1, '1, 8'hFF));
		send_cmd(mk_cmd(CMD_ALLOC, 8'h00, 8'h00, RESP_FREE, 1'b0, '0, 8'h00));
		send_cmd(mk_cmd(CMD_ALLOC, 8'h00, 8'h00, 8'h01, 1'b0, '0, 8'h00));
		send_cmd(mk_cmd(CMD_QUERY, 8'd1, '0, '0, 1'b0, '0, '0));
		send_cmd(mk_cmd(CMD_SET_CHANNEL, 8'd1, '0, '0, 1'b0, '0, 8'hFF));
		send_cmd(mk_cmd(CMD_VALIDATE, 8'd1, '0, 8'hFF, 1'b0, '0, 8'hFF));
		send_cmd(mk_cmd(CMD_VALIDATE, 8'd1, '0, 8'h7E, 1'b0, '0, 8'hFF));
		send_cmd(mk_cmd(CMD_VALIDATE, 8'd1, '0, FAULT_RESET, 1'b0, '0, 8'hFF));
		send_cmd(mk_cmd(CMD_VALIDATE, 8'd1, '0, 8'hFF, 1'b0, '0, 8'h00));
		send_cmd(mk_cmd(CMD_VALIDATE, 8'd2, '0, 8'h01, 1'b0, '0, 8'h00));
		send_cmd(mk_cmd(CMD_VALIDATE, 8'd0, '0, 8'h01, 1'b0, '0, 8'h00));
		send_cmd(mk_cmd(CMD_VALIDATE, HANDLE_LAST + 8'd1, '0, 8'h01, 1'b0, '0, 8'h00));
		send_cmd(mk_cmd(CMD_SET_CHANNEL, 8'd5, '0, '0, 1'b0, '0, 8'h5A));
		send_cmd(mk_cmd(CMD_QUERY, 8'd5, '0, '0, 1'b0, '0, '0));
		send_cmd(mk_cmd(CMD_QUERY, 8'd0, '0, '0, 1'b0, '0, '0));
		send_cmd(mk_cmd(CMD_QUERY, HANDLE_LAST, '0, '0, 1'b0, '0, '0));
		send_cmd(mk_cmd(CMD_QUERY, 8'hFF, '1, '1, 1'b1, '1, '1));
		send_cmd(mk_cmd(CMD_SET_CHANNEL, HANDLE_LAST + 8'd1, '0, '0, 1'b0, '0, 8'h33));
		send_cmd(mk_cmd(CMD_REMOVE, 8'hFF, '0, '0, 1'b0, '0, '0));
		send_cmd(mk_cmd(CMD_REMOVE, 8'd1, '0, '0, 1'b0, '0, '0));
		send_cmd(mk_cmd(CMD_QUERY, 8'd1, '0, '0, 1'b0, '0, '0));
		send_cmd(mk_cmd(CMD_VALIDATE, 8'd1, '0, 8'hFF, 1'b0, '0, 8'hFF));
		for (logic [3:0] c = 4'(CMD_SPARE_LO); c <= 4'(CMD_SPARE_HI); c++)
			send_cmd(mk_cmd(c[2:0], 8'hFF, '1, '1, 1'b1, '1, '1));
	endtask

	// Fault code at its top value: any live slot validates with it, the old
	// code no longer does.
	task automatic test_fault_code();
		write_fault_code(8'hFF);
		send_cmd(mk_cmd(CMD_ALLOC, 8'h00, 8'h12, 8'h10, 1'b1, 64'h0123_4567_89AB_CDEF, 8'h00));
		send_cmd(mk_cmd(CMD_VALIDATE, 8'd2, '0, 8'hFF, 1'b0, '0, 8'h00));
		send_cmd(mk_cmd(CMD_VALIDATE, 8'd3, '0, 8'hFF, 1'b0, '0, 8'h00));
		send_cmd(mk_cmd(CMD_VALIDATE, 8'd3, '0, FAULT_RESET, 1'b0, '0, 8'h00));
		send_cmd(mk_cmd(CMD_VALIDATE, 8'd3, '0, 8'h10, 1'b0, '0, 8'h00));
		write_fault_code(FAULT_RESET);
		send_cmd(mk_cmd(CMD_VALIDATE, 8'd3, '0, FAULT_RESET, 1'b0, '0, 8'h00));
	endtask

	// Fill every slot, allocate into a full table, free a few and reclaim
	// them in cursor order, then empty the table again.
	task automatic test_table_full();
		while (live_count() < PENDING_SLOTS)
			send_cmd(mk_cmd(CMD_ALLOC, 8'($urandom), 8'($urandom),
			                8'($urandom_range(255, 1)), 1'($urandom), rand_word(),
			                8'($urandom)));
		send_cmd(mk_cmd(CMD_ALLOC, 8'h00, 8'hAA, 8'h55, 1'b1, '1, 8'h00));
		send_cmd(mk_cmd(CMD_REMOVE, 8'd1, '0, '0, 1'b0, '0, '0));
		send_cmd(mk_cmd(CMD_REMOVE, 8'd64, '0, '0, 1'b0, '0, '0));
		send_cmd(mk_cmd(CMD_REMOVE, HANDLE_LAST, '0, '0, 1'b0, '0, '0));
		send_cmd(mk_cmd(CMD_SET_CHANNEL, 8'd64, '0, '0, 1'b0, '0, 8'h77));
		repeat (4)
			send_cmd(mk_cmd(CMD_ALLOC, 8'h00, 8'($urandom), 8'($urandom_range(255, 1)),
			                1'($urandom), rand_word(), 8'h00));
		send_cmd(mk_cmd(CMD_QUERY, 8'd64, '0, '0, 1'b0, '0, '0));
		for (int i = 1; i <= PENDING_SLOTS; i++)
			send_cmd(mk_cmd(CMD_REMOVE, 8'(i), '0, '0, 1'b0, '0, '0));
	endtask

	// Results held off for a long stretch while commands keep coming, so the
	// block fills and stalls its command port; then the sender waits for all.
	task automatic test_backpressure();
		wait_drain();
		rsp_hold_cycles = HOLD_OFF_LEN;
		repeat (16)
			send_cmd(rand_cmd(45));
		wait_drain();
	endtask

	// Random phases, each under its own fault code. One phase runs with no
	// idling on either side, one leans hard on allocate to reach a full table.
	task automatic test_random();
		logic [7:0] codes [4];
		codes = '{8'hFF, 8'($urandom_range(254, 2)), FAULT_RESET, 8'h80};
		for (int p = 0; p < 4; p++) begin
			write_fault_code(codes[p]);
			req_idle_pct = (p == 1) ? 0 : IDLE_PCT;
			rsp_idle_pct = (p == 1) ? 0 : IDLE_PCT;
			repeat (400)
				send_cmd(rand_cmd((p == 2) ? 70 : 35));
		end
		req_idle_pct = IDLE_PCT;
		rsp_idle_pct = IDLE_PCT;
	endtask

	initial begin
		req_ch.valid           = 1'b0;
		req_ch.command         = CMD_ALLOC;
		req_ch.handle          = '0;
		req_ch.request_type    = '0;
		req_ch.response_type   = '0;
		req_ch.has_app_context = 1'b0;
		req_ch.app_context     = '0;
		req_ch.channel         = '0;
		rsp_ch.ready           = 1'b0;
		cfg_ch.valid           = 1'b0;
		cfg_ch.fault_response_code = FAULT_RESET;
		for (int i = 0; i < TABLE_DEPTH; i++)
			slot_tbl[i] = '0;
		tag_cursor = '0;
		fault_code = FAULT_RESET;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_ops();
		test_fault_code();
		test_table_full();
		test_backpressure();
		test_random();

		wait_drain();
		repeat (16) @(posedge clk);
		if (result_q.size() != 0) begin
			$error("%0d predicted results never arrived", result_q.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule
